>>> src/tobsa_pkg.sv
// Shared constants, register codes and helper functions for the two-order buddy
// slot allocator. No dependencies.
package tobsa_pkg;

    // Bitmaps are stored as 32-bit words with one summary bit per word.
    localparam int WORD_W  = 32;
    localparam int WORD_AW = 5;

    // Configuration port geometry.
    localparam int APB_AW = 4;
    localparam int APB_DW = 64;

    // Register index, taken from paddr[3].
    localparam logic REG_DMA_BASE = 1'b0;

    // Request codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;
    localparam logic ORDER_SINGLE = 1'b0;
    localparam logic ORDER_PAIR   = 1'b1;

    // Lowest set bit of a word. Returns 0 when the word is empty.
    function automatic logic [WORD_AW-1:0] f_low_bit(input logic [WORD_W-1:0] w);
        logic [WORD_AW-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = WORD_AW'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> src/two_order_buddy_slot_allocator.sv
// Top level of the two-order buddy slot allocator: request decode, bitmap
// update, free pair count and result pipeline. Depends on tobsa_pkg,
// tobsa_cfg and tobsa_map.
//
// One request (allocate or free) is taken on every cycle in which start is
// high and busy is low; busy is high only in the first cycle after reset.
// Each request gives exactly one result on o_done, registered through r_v1
// and r_done, and results follow back to back at one per cycle. The bitmap
// update for a request completes at the edge that takes it, so the next
// request sees it. The lowest free entry is found through one summary bit
// per 32-entry word followed by an encoder over the chosen word; dma_addr is
// then formed from the registered granted index. The receiver cannot stall:
// o_done is high for one cycle only.
module two_order_buddy_slot_allocator #(
    parameter int DB_SLOTS   = 1024,
    parameter int UNIT_BYTES = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic                          i_order,
    input  logic [9:0]                    i_slot_index,
    output logic                          o_done,
    output logic                          o_status,
    output logic [9:0]                    o_granted_index,
    output logic [63:0]                   o_dma_addr,
    output logic                          o_page_empty,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tobsa_pkg::APB_AW-1:0]  paddr,
    input  logic [tobsa_pkg::APB_DW-1:0]  pwdata,
    output logic [tobsa_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import tobsa_pkg::*;

    localparam int NPAIRS = DB_SLOTS / 2;
    localparam int NSW    = (DB_SLOTS + WORD_W - 1) / WORD_W;
    localparam int NPW    = (NPAIRS + WORD_W - 1) / WORD_W;
    localparam int SAW    = (NSW > 1) ? $clog2(NSW) : 1;
    localparam int PAW    = (NPW > 1) ? $clog2(NPW) : 1;
    localparam int CW     = $clog2(NPAIRS + 1);

    logic [63:0]        w_dma_base;
    logic               w_acc;
    logic [31:0]        w_idx;
    logic               w_slot_in;
    logic               w_pair_in;

    logic [SAW-1:0]     s_rd_addr, s_low, s_wa;
    logic [WORD_W-1:0]  s_word, s_wd;
    logic               s_any, s_we;
    logic [PAW-1:0]     p_rd_addr, p_low, p_wa;
    logic [WORD_W-1:0]  p_word, p_wd;
    logic               p_any, p_we;
    logic [WORD_AW-1:0] s_bit, p_bit, w_buddy_bit, w_pbit;
    logic [31:0]        w_pk;

    logic [CW-1:0]      r_cnt, n_cnt;
    logic [31:0]        n_slot;
    logic               n_ok, n_status;

    logic               r_rdy;
    logic               r_v1, r_ok1, r_st1, r_empty1;
    logic [9:0]         r_gidx1;
    logic               r_done, r_status, r_empty;
    logic [9:0]         r_gidx;
    logic [63:0]        r_dma;

    tobsa_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_dma_base (w_dma_base)
    );

    tobsa_map #(.NBITS(DB_SLOTS), .FILL(1'b0)) u_single (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (s_rd_addr),
        .o_rd_word  (s_word),
        .o_low_addr (s_low),
        .o_any      (s_any),
        .i_we       (s_we && w_acc),
        .i_wr_addr  (s_wa),
        .i_wr_word  (s_wd)
    );

    tobsa_map #(.NBITS(NPAIRS), .FILL(1'b1)) u_pair (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (p_rd_addr),
        .o_rd_word  (p_word),
        .o_low_addr (p_low),
        .o_any      (p_any),
        .i_we       (p_we && w_acc),
        .i_wr_addr  (p_wa),
        .i_wr_word  (p_wd)
    );

    assign busy      = !r_rdy;
    assign w_acc     = start && !busy;
    assign w_idx     = 32'(i_slot_index);
    assign w_slot_in = w_idx < 32'(DB_SLOTS);
    assign w_pair_in = (w_idx >> 1) < 32'(NPAIRS);

    // Allocate searches for the lowest word; free looks at the word of slot_index.
    assign s_rd_addr = (i_func == FUNC_FREE) ? w_idx[WORD_AW +: SAW] : s_low;
    assign p_rd_addr = (i_func == FUNC_FREE) ? w_idx[WORD_AW + 1 +: PAW] : p_low;

    assign s_bit       = f_low_bit(s_word);
    assign p_bit       = f_low_bit(p_word);
    assign w_pk        = (32'(p_low) << WORD_AW) | 32'(p_bit);
    assign w_buddy_bit = w_idx[WORD_AW-1:0] ^ WORD_AW'(1);
    assign w_pbit      = w_idx[WORD_AW:1];

    always_comb begin
        n_cnt    = r_cnt;
        n_slot   = '0;
        n_ok     = 1'b0;
        n_status = 1'b0;
        s_we     = 1'b0;
        s_wa     = s_rd_addr;
        s_wd     = s_word;
        p_we     = 1'b0;
        p_wa     = p_rd_addr;
        p_wd     = p_word;
        if (i_func == FUNC_ALLOC) begin
            if (i_order == ORDER_SINGLE && s_any) begin
                n_slot = (32'(s_low) << WORD_AW) | 32'(s_bit);
                n_ok   = 1'b1;
                s_we   = 1'b1;
                s_wd   = s_word & ~(WORD_W'(1) << s_bit);
            end else if (p_any) begin
                n_slot = w_pk << 1;
                n_ok   = 1'b1;
                p_we   = 1'b1;
                p_wd   = p_word & ~(WORD_W'(1) << p_bit);
                n_cnt  = r_cnt - CW'(1);
                // Split: the odd buddy becomes a free single. Singles are all
                // taken here, so its word holds only that bit.
                if (i_order == ORDER_SINGLE) begin
                    s_we = 1'b1;
                    s_wa = w_pk[WORD_AW - 1 +: SAW];
                    s_wd = WORD_W'(1) << {w_pk[WORD_AW-2:0], 1'b1};
                end
            end else begin
                n_status = 1'b1;
            end
        end else if (i_order == ORDER_SINGLE) begin
            if (w_slot_in) begin
                s_we = 1'b1;
                if (w_pair_in && s_word[w_buddy_bit]) begin
                    // Merge with the free buddy back into a pair.
                    s_wd = s_word & ~(WORD_W'(1) << w_buddy_bit);
                    p_we = 1'b1;
                    p_wd = p_word | (WORD_W'(1) << w_pbit);
                    if (!p_word[w_pbit]) begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end else begin
                    s_wd = s_word | (WORD_W'(1) << w_idx[WORD_AW-1:0]);
                end
            end
        end else if (w_pair_in) begin
            p_we = 1'b1;
            p_wd = p_word | (WORD_W'(1) << w_pbit);
            if (!p_word[w_pbit]) begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy  <= 1'b0;
            r_cnt  <= CW'(NPAIRS);
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_rdy  <= 1'b1;
            r_v1   <= w_acc;
            r_done <= r_v1;
            if (w_acc) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ok1    <= n_ok;
            r_st1    <= n_status;
            r_gidx1  <= n_slot[9:0];
            r_empty1 <= (i_func == FUNC_FREE) && (n_cnt == CW'(NPAIRS));
        end
        r_status <= r_st1;
        r_gidx   <= r_gidx1;
        r_empty  <= r_empty1;
        r_dma    <= r_ok1 ? (w_dma_base + 64'(r_gidx1) * 64'(UNIT_BYTES)) : '0;
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_index = r_gidx;
    assign o_dma_addr      = r_dma;
    assign o_page_empty    = r_empty;

endmodule

>>> src/tobsa_cfg.sv
// APB-style configuration register holding the record page base address.
// Depends on tobsa_pkg.
module tobsa_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tobsa_pkg::APB_AW-1:0]  paddr,
    input  logic [tobsa_pkg::APB_DW-1:0]  pwdata,
    output logic [tobsa_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output logic [63:0]                   o_dma_base
);
    import tobsa_pkg::*;

    logic [63:0] r_dma_base;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dma_base <= '0;
        end else if (w_wr) begin
            unique case (paddr[3])
                REG_DMA_BASE: r_dma_base <= pwdata;
                default:      r_dma_base <= r_dma_base;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_DMA_BASE: prdata = r_dma_base;
            default:      prdata = '0;
        endcase
    end

    assign o_dma_base = r_dma_base;

endmodule

>>> src/tobsa_map.sv
// Word-organized free bitmap with one summary bit per word: one read port,
// one write port and a lowest-nonempty-word search. Depends on tobsa_pkg.
module tobsa_map #(
    parameter int NBITS = 1024,
    parameter bit FILL  = 1'b0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [((NBITS+31)/32 > 1 ? $clog2((NBITS+31)/32) : 1)-1:0] i_rd_addr,
    output logic [tobsa_pkg::WORD_W-1:0]        o_rd_word,
    output logic [((NBITS+31)/32 > 1 ? $clog2((NBITS+31)/32) : 1)-1:0] o_low_addr,
    output logic                                o_any,
    input  logic                                i_we,
    input  logic [((NBITS+31)/32 > 1 ? $clog2((NBITS+31)/32) : 1)-1:0] i_wr_addr,
    input  logic [tobsa_pkg::WORD_W-1:0]        i_wr_word
);
    import tobsa_pkg::*;

    localparam int NW = (NBITS + WORD_W - 1) / WORD_W;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;

    logic [WORD_W-1:0] r_word [NW];
    logic [NW-1:0]     r_nz;

    // Bits past the end of the map never become free.
    function automatic logic [WORD_W-1:0] f_fill(input int w);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = FILL && ((w * WORD_W + b) < NBITS);
        end
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NW; w++) begin
                r_word[w] <= f_fill(w);
            end
            r_nz <= {NW{FILL}};
        end else if (i_we) begin
            r_word[i_wr_addr] <= i_wr_word;
            r_nz[i_wr_addr]   <= |i_wr_word;
        end
    end

    always_comb begin
        o_low_addr = '0;
        for (int w = NW - 1; w >= 0; w--) begin
            if (r_nz[w]) begin
                o_low_addr = AW'(w);
            end
        end
    end

    assign o_any     = |r_nz;
    assign o_rd_word = (32'(i_rd_addr) < 32'(NW)) ? r_word[i_rd_addr] : '0;

endmodule

>>> src/tobsa_chk.sv
// Port-level checker for the two-order buddy slot allocator, with its bind.
// Depends on two_order_buddy_slot_allocator.
module tobsa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_func,
    input logic        i_order,
    input logic        o_done,
    input logic        o_status,
    input logic [9:0]  o_granted_index,
    input logic [63:0] o_dma_addr,
    input logic        o_page_empty
);

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without an accepted transaction");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_granted_index == 10'd0 && o_dma_addr == 64'd0))
        else $error("failed allocate returned an index or address");

    a_empty_on_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_page_empty) |-> $past(i_func, 2))
        else $error("page_empty reported on an allocate");

    a_pair_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_status && $past(!i_func && i_order, 2)) |-> !o_granted_index[0])
        else $error("pair grant at odd slot");

endmodule

bind two_order_buddy_slot_allocator tobsa_chk u_tobsa_chk (.*);
